>>> hw/rtl/tdes_pkg.sv
package tdes_pkg;

    localparam int ID_W    = 28;
    localparam int PAY_W   = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int TIME_W  = HOUR_W + MIN_W;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int MIN_SHIFT = 17;
    localparam int WORD_W  = ID_W + PAY_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD_TIME = 3'd0,
        ACT_ADD_ID   = 3'd1,
        ACT_REMOVE   = 3'd2,
        ACT_RETIME   = 3'd3,
        ACT_TICK     = 3'd4
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

>>> hw/rtl/tdes_ram.sv
module tdes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/time_of_day_event_scheduler_top.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-------------------------------------------
// s_       | in        | s_valid / s_ready  | s_action s_hours s_minutes s_payload s_event_id
// m_       | out       | m_valid / m_ready  | m_status m_new_id m_fire m_fire_payload
//
// after the accept the scan reads the TABLE_DEPTH table entries in address order, the ram
// data trailing the address by one register, then one finish step writes back and loads
// the result register; the block returns to idle in the cycle after the finish step, so it
// takes the next transaction only once the last one is through.
// s_ready is high only in idle; a held result in the output register does not block
// accepting the next transaction, the finish step waits only if it is still held.
// synchronous active-low reset clears the valid bits, last-fired id and handshakes;
// table contents are not cleared, an entry is only read when its valid bit is set.
module time_of_day_event_scheduler_top
    import tdes_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACT_W-1:0]    s_action,
    input  logic [HOUR_W-1:0]   s_hours,
    input  logic [MIN_W-1:0]    s_minutes,
    input  logic [PAY_W-1:0]    s_payload,
    input  logic [ID_W-1:0]     s_event_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [ID_W-1:0]     m_new_id,
    output logic                m_fire,
    output logic [PAY_W-1:0]    m_fire_payload
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    // control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pv_reg, pv_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]    lf_reg, lf_next;
    logic               m_valid_reg, m_valid_next;

    // transaction and scan working registers
    logic [ACT_W-1:0]   act_reg, act_next;
    logic [HOUR_W-1:0]  hrs_reg, hrs_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [PAY_W-1:0]   pay_reg, pay_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   fidx_reg, fidx_next;
    logic [PAY_W-1:0]   fpay_reg, fpay_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   freeidx_reg, freeidx_next;
    logic               any_reg, any_next;
    logic [ID_W-1:0]    any_id_reg, any_id_next;
    logic [PAY_W-1:0]   any_pay_reg, any_pay_next;
    logic               aft_reg, aft_next;
    logic [ID_W-1:0]    aft_id_reg, aft_id_next;
    logic [PAY_W-1:0]   aft_pay_reg, aft_pay_next;

    // result register
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [ID_W-1:0]    m_new_id_reg, m_new_id_next;
    logic               m_fire_reg, m_fire_next;
    logic [PAY_W-1:0]   m_fpay_reg, m_fpay_next;

    // table ram: {id, payload}
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [PAY_W-1:0]   rd_pay;
    logic               rd_vld;

    // finish step helpers
    logic [ID_W-1:0]    pick_id;
    logic [PAY_W-1:0]   pick_pay;
    logic [TIME_W-1:0]  now;
    logic               due;
    logic [ID_W-1:0]    retimed_id;

    tdes_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_id  = ram_rdata[WORD_W-1:PAY_W];
    assign rd_pay = ram_rdata[PAY_W-1:0];
    assign rd_vld = pv_reg & valid_reg[pidx_reg];

    assign now        = {hrs_reg, min_reg};
    assign pick_id    = aft_reg ? aft_id_reg : any_id_reg;
    assign pick_pay   = aft_reg ? aft_pay_reg : any_pay_reg;
    assign due        = (pick_id[ID_W-1:MIN_SHIFT] == now);
    assign retimed_id = {hrs_reg, min_reg, 1'b0, fpay_reg};

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_new_id       = m_new_id_reg;
    assign m_fire         = m_fire_reg;
    assign m_fire_payload = m_fpay_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pv_next       = 1'b0;
        pidx_next     = pidx_reg;
        valid_next    = valid_reg;
        lf_next       = lf_reg;
        m_valid_next  = m_valid_reg;
        act_next      = act_reg;
        hrs_next      = hrs_reg;
        min_next      = min_reg;
        pay_next      = pay_reg;
        key_next      = key_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        fpay_next     = fpay_reg;
        free_next     = free_reg;
        freeidx_next  = freeidx_reg;
        any_next      = any_reg;
        any_id_next   = any_id_reg;
        any_pay_next  = any_pay_reg;
        aft_next      = aft_reg;
        aft_id_next   = aft_id_reg;
        aft_pay_next  = aft_pay_reg;
        m_status_next = m_status_reg;
        m_new_id_next = m_new_id_reg;
        m_fire_next   = m_fire_reg;
        m_fpay_next   = m_fpay_reg;
        ram_we        = 1'b0;
        ram_waddr     = freeidx_reg;
        ram_wdata     = {key_reg, pay_reg};
        ram_re        = 1'b0;
        ram_raddr     = cnt_reg[IDX_W-1:0];

        // result leaves when taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // scan unit: one entry per cycle, working on the registered ram data of the previous address
        if (pv_reg) begin
            if (rd_vld && (rd_id == key_reg) && !found_reg) begin
                found_next = 1'b1;
                fidx_next  = pidx_reg;
                fpay_next  = rd_pay;
            end
            if (!valid_reg[pidx_reg] && !free_reg) begin
                free_next    = 1'b1;
                freeidx_next = pidx_reg;
            end
            if (rd_vld && (!any_reg || (rd_id < any_id_reg))) begin
                any_next     = 1'b1;
                any_id_next  = rd_id;
                any_pay_next = rd_pay;
            end
            if (rd_vld && (rd_id[ID_W-1:MIN_SHIFT] >= now)
                    && (!aft_reg || (rd_id < aft_id_reg))) begin
                aft_next     = 1'b1;
                aft_id_next  = rd_id;
                aft_pay_next = rd_pay;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    hrs_next   = s_hours;
                    min_next   = s_minutes;
                    pay_next   = (s_action == ACT_ADD_ID) ? s_event_id[PAY_W-1:0] : s_payload;
                    key_next   = (s_action == ACT_ADD_TIME)
                               ? {s_hours, s_minutes, 1'b0, s_payload} : s_event_id;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    any_next   = 1'b0;
                    aft_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg < CNT_W'(TABLE_DEPTH)) begin
                    ram_re    = 1'b1;
                    pv_next   = 1'b1;
                    pidx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_new_id_next = '0;
                    m_fire_next   = 1'b0;
                    m_fpay_next   = '0;
                    state_next    = S_IDLE;
                    case (act_reg)
                        ACT_ADD_TIME, ACT_ADD_ID: begin
                            if (found_reg) begin
                                m_status_next = ST_DUPLICATE;
                            end else if (!free_reg) begin
                                m_status_next = ST_FULL;
                            end else begin
                                ram_we                  = 1'b1;
                                valid_next[freeidx_reg] = 1'b1;
                            end
                        end
                        ACT_REMOVE: begin
                            if (found_reg) begin
                                valid_next[fidx_reg] = 1'b0;
                            end else begin
                                m_status_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_RETIME: begin
                            if (found_reg) begin
                                ram_we        = 1'b1;
                                ram_waddr     = fidx_reg;
                                ram_wdata     = {retimed_id, fpay_reg};
                                m_new_id_next = retimed_id;
                            end else begin
                                m_status_next = ST_NOT_FOUND;
                            end
                        end
                        ACT_TICK: begin
                            // fall back to the earliest entry when none is at or after the tick time
                            if (any_reg) begin
                                if (due && (lf_reg != pick_id)) begin
                                    m_fire_next = 1'b1;
                                    m_fpay_next = pick_pay;
                                    lf_next     = pick_id;
                                end else if (!due && (lf_reg == pick_id)) begin
                                    lf_next = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pv_reg      <= 1'b0;
            valid_reg   <= '0;
            lf_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pv_reg      <= pv_next;
            valid_reg   <= valid_next;
            lf_reg      <= lf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        hrs_reg      <= hrs_next;
        min_reg      <= min_next;
        pay_reg      <= pay_next;
        key_reg      <= key_next;
        pidx_reg     <= pidx_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        fpay_reg     <= fpay_next;
        free_reg     <= free_next;
        freeidx_reg  <= freeidx_next;
        any_reg      <= any_next;
        any_id_reg   <= any_id_next;
        any_pay_reg  <= any_pay_next;
        aft_reg      <= aft_next;
        aft_id_reg   <= aft_id_next;
        aft_pay_reg  <= aft_pay_next;
        m_status_reg <= m_status_next;
        m_new_id_reg <= m_new_id_next;
        m_fire_reg   <= m_fire_next;
        m_fpay_reg   <= m_fpay_next;
    end

endmodule

>>> hw/rtl/tdes_checker.sv
module tdes_checker
    import tdes_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STAT_W-1:0]   m_status,
    input logic [ID_W-1:0]     m_new_id,
    input logic                m_fire,
    input logic [PAY_W-1:0]    m_fire_payload
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_new_id)
            && $stable(m_fire) && $stable(m_fire_payload))
        else $error("result changed while stalled");

    // no fire payload without a fire
    a_fpay: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_fire |-> m_fire_payload == '0)
        else $error("fire payload without fire");

    // a fire is always a clean tick result
    a_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fire |-> m_status == ST_OK && m_new_id == '0)
        else $error("fire with status or new id");

    // a new id only comes with an ok status
    a_newid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_id != '0 |-> m_status == ST_OK)
        else $error("new id with error status");

    // the scan follows every accept, so no accept right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

endmodule

bind time_of_day_event_scheduler_top tdes_checker u_tdes_checker (.*);

>>> tb/sv/tb_time_of_day_event_scheduler_top.sv
module tb_time_of_day_event_scheduler_top;
    import tdes_pkg::*;

    // sizes of the run
    localparam int DEPTH           = 16;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int IDLE_PERCENT    = 21;
    localparam int SCRIPT_ROWS     = 20;

    // action codes the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    // ids used by the directed part
    localparam logic [ID_W-1:0] ID_LATEST = 28'hBF6FFFF; // 23:59, payload ffff
    localparam logic [ID_W-1:0] ID_TOP    = 28'hFFFFFFF;
    localparam logic [ID_W-1:0] ID_MOVED  = 28'h000FFFF; // top id moved to 00:00
    localparam logic [ID_W-1:0] ID_FILL   = 28'h0020000; // 00:01, low part counts up

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [PAY_W-1:0]  payload;
        logic [ID_W-1:0]   event_id;
    } alarm_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   new_id;
        logic              fire;
        logic [PAY_W-1:0]  fire_payload;
    } alarm_res_t;

    // one line of the directed table; reps > 1 steps event_id by one per copy
    typedef struct packed {
        alarm_req_t req;
        logic [4:0] reps;
        logic       has_answer;
        alarm_res_t answer;
    } script_row_t;

    // answers that can be read straight off the behavior
    localparam alarm_res_t RES_OK       = '{ST_OK, '0, 1'b0, '0};
    localparam alarm_res_t RES_DUP      = '{ST_DUPLICATE, '0, 1'b0, '0};
    localparam alarm_res_t RES_MISSING  = '{ST_NOT_FOUND, '0, 1'b0, '0};
    localparam alarm_res_t RES_FULL     = '{ST_FULL, '0, 1'b0, '0};
    localparam alarm_res_t RES_FIRE_TOP = '{ST_OK, '0, 1'b1, 16'hFFFF};
    localparam alarm_res_t RES_MOVED    = '{ST_OK, ID_MOVED, 1'b0, '0};

    // directed part: empty table, duplicates, fill to full, firing order,
    // id zero, out-of-range tick time, clearing of the last fired id,
    // retime onto an existing id, remove of a doubled id, ignored actions
    localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
        '{'{ACT_TICK,      5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_OK},
        '{'{ACT_REMOVE,    5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_MISSING},
        '{'{ACT_ADD_TIME,  5'd23, 6'd59, 16'hFFFF, 28'h0},      5'd1,  1'b1, RES_OK},
        '{'{ACT_ADD_TIME,  5'd23, 6'd59, 16'hFFFF, 28'h0},      5'd1,  1'b1, RES_DUP},
        '{'{ACT_ADD_ID,    5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_OK},
        '{'{ACT_ADD_ID,    5'd0,  6'd0,  16'h0000, ID_TOP},     5'd1,  1'b1, RES_OK},
        '{'{ACT_ADD_ID,    5'd0,  6'd0,  16'h0000, ID_FILL},    5'd13, 1'b1, RES_OK},
        '{'{ACT_ADD_TIME,  5'd1,  6'd2,  16'hA5A5, 28'h0},      5'd1,  1'b1, RES_FULL},
        '{'{ACT_ADD_ID,    5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_DUP},
        '{'{ACT_TICK,      5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_OK},
        '{'{ACT_TICK,      5'd23, 6'd59, 16'h0000, 28'h0},      5'd1,  1'b1, RES_FIRE_TOP},
        '{'{ACT_TICK,      5'd31, 6'd63, 16'h0000, 28'h0},      5'd1,  1'b1, RES_FIRE_TOP},
        '{'{ACT_TICK,      5'd24, 6'd0,  16'h0000, 28'h0},      5'd1,  1'b0, RES_OK},
        '{'{ACT_TICK,      5'd31, 6'd63, 16'h0000, 28'h0},      5'd1,  1'b0, RES_OK},
        '{'{ACT_RETIME,    5'd0,  6'd0,  16'h0000, ID_TOP},     5'd1,  1'b1, RES_MOVED},
        '{'{ACT_RETIME,    5'd23, 6'd59, 16'h0000, ID_MOVED},   5'd1,  1'b0, RES_OK},
        '{'{ACT_REMOVE,    5'd0,  6'd0,  16'h0000, ID_LATEST},  5'd1,  1'b0, RES_OK},
        '{'{ACT_RETIME,    5'd5,  6'd5,  16'h0000, 28'h1234567}, 5'd1, 1'b1, RES_MISSING},
        '{'{ACT_UNUSED_LO, 5'd31, 6'd63, 16'hFFFF, ID_TOP},     5'd1,  1'b1, RES_OK},
        '{'{ACT_UNUSED_HI, 5'd0,  6'd0,  16'h0000, 28'h0},      5'd1,  1'b1, RES_OK}
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [ACT_W-1:0]  s_action;
    logic [HOUR_W-1:0] s_hours;
    logic [MIN_W-1:0]  s_minutes;
    logic [PAY_W-1:0]  s_payload;
    logic [ID_W-1:0]   s_event_id;
    logic              m_valid;
    logic              m_ready;
    logic [STAT_W-1:0] m_status;
    logic [ID_W-1:0]   m_new_id;
    logic              m_fire;
    logic [PAY_W-1:0]  m_fire_payload;

    // mirror of the alarm table, updated at each accepted transaction
    logic              alarm_valid [DEPTH];
    logic [ID_W-1:0]   alarm_id    [DEPTH];
    logic [PAY_W-1:0]  alarm_pay   [DEPTH];
    logic [ID_W-1:0]   fired_id;

    alarm_res_t        alarm_outcomes_q [$];
    int                fail_count  = 0;
    int                cycle_count = 0;
    bit                calm_stretch = 1'b0;  // no idling on either side
    bit                hold_request = 1'b0;  // asks the receiver for a long hold-off

    time_of_day_event_scheduler_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_hours       (s_hours),
        .s_minutes     (s_minutes),
        .s_payload     (s_payload),
        .s_event_id    (s_event_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_new_id      (m_new_id),
        .m_fire        (m_fire),
        .m_fire_payload(m_fire_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // lowest valid slot holding the id, or -1
    function automatic int find_alarm(logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (alarm_valid[i] && alarm_id[i] == id)
                return i;
        return -1;
    endfunction

    // duplicate test comes first, then the lowest free slot
    function automatic logic [STAT_W-1:0] insert_alarm(logic [ID_W-1:0] id,
                                                       logic [PAY_W-1:0] pay);
        if (find_alarm(id) >= 0)
            return ST_DUPLICATE;
        for (int i = 0; i < DEPTH; i++) begin
            if (!alarm_valid[i]) begin
                alarm_valid[i] = 1'b1;
                alarm_id[i]    = id;
                alarm_pay[i]   = pay;
                return ST_OK;
            end
        end
        return ST_FULL;
    endfunction

    // applies one transaction to the mirror and returns the result it causes
    function automatic alarm_res_t step_alarm_table(alarm_req_t req);
        alarm_res_t        res;
        int                slot;
        int                after_pick;
        int                any_pick;
        int                pick;
        logic [TIME_W-1:0] now;
        bit                due;
        res = '0;
        case (req.action)
            ACT_ADD_TIME: begin
                res.status = insert_alarm({req.hours, req.minutes, 1'b0, req.payload},
                                          req.payload);
            end
            ACT_ADD_ID: begin
                res.status = insert_alarm(req.event_id, req.event_id[PAY_W-1:0]);
            end
            ACT_REMOVE: begin
                slot = find_alarm(req.event_id);
                if (slot < 0)
                    res.status = ST_NOT_FOUND;
                else
                    alarm_valid[slot] = 1'b0;
            end
            ACT_RETIME: begin
                slot = find_alarm(req.event_id);
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    alarm_id[slot] = {req.hours, req.minutes, 1'b0, alarm_pay[slot]};
                    res.new_id     = alarm_id[slot];
                end
            end
            ACT_TICK: begin
                now        = {req.hours, req.minutes};
                after_pick = -1;
                any_pick   = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (alarm_valid[i]) begin
                        if (any_pick < 0 || alarm_id[i] < alarm_id[any_pick])
                            any_pick = i;
                        if (alarm_id[i][ID_W-1:MIN_SHIFT] >= now &&
                            (after_pick < 0 || alarm_id[i] < alarm_id[after_pick]))
                            after_pick = i;
                    end
                end
                pick = (after_pick >= 0) ? after_pick : any_pick;
                if (pick >= 0) begin
                    due = (alarm_id[pick][ID_W-1:MIN_SHIFT] == now);
                    if (due && fired_id != alarm_id[pick]) begin
                        res.fire         = 1'b1;
                        res.fire_payload = alarm_pay[pick];
                        fired_id         = alarm_id[pick];
                    end else if (!due && fired_id == alarm_id[pick]) begin
                        fired_id = '0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // id of a random live entry, or a random id when the table is empty
    function automatic logic [ID_W-1:0] pick_live_id();
        int live_slots [$];
        for (int i = 0; i < DEPTH; i++)
            if (alarm_valid[i])
                live_slots = {live_slots, i};
        if (live_slots.size() == 0)
            return ID_W'($urandom);
        return alarm_id[live_slots[$urandom_range(live_slots.size() - 1)]];
    endfunction

    // offers one transaction, waits for the accept edge, then records its outcome;
    // a directed row with a typed answer stores that answer instead
    task automatic offer_request(alarm_req_t req, bit has_answer, alarm_res_t answer);
        alarm_res_t outcome;
        while (!calm_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= req.action;
        s_hours    <= req.hours;
        s_minutes  <= req.minutes;
        s_payload  <= req.payload;
        s_event_id <= req.event_id;
        do
            @(posedge aclk);
        while (!s_ready);
        outcome = step_alarm_table(req);
        alarm_outcomes_q = {alarm_outcomes_q, (has_answer ? answer : outcome)};
    endtask

    // receiver: checks every accepted result against the oldest outcome and
    // drives m_ready, including one long hold-off so the block backs up
    initial begin
        alarm_res_t got;
        alarm_res_t want;
        int         hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_status, m_new_id, m_fire, m_fire_payload};
                if (alarm_outcomes_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("cycle %0d: result with nothing outstanding: %p",
                                 cycle_count, got);
                end else begin
                    want = alarm_outcomes_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"cycle %0d: mismatch status %0d/%0d new_id %h/%h ",
                                      "fire %0d/%0d fire_payload %h/%h (expected/actual)"},
                                     cycle_count, want.status, got.status,
                                     want.new_id, got.new_id, want.fire, got.fire,
                                     want.fire_payload, got.fire_payload);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // sender: reset, directed table, then random traffic, then drain
    initial begin
        alarm_req_t      req;
        logic [ID_W-1:0] live;
        int              roll;
        int              sub;
        int              accepted;
        int              clock_min;
        bit              hold_sent;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_action   = '0;
        s_hours    = '0;
        s_minutes  = '0;
        s_payload  = '0;
        s_event_id = '0;
        for (int i = 0; i < DEPTH; i++) begin
            alarm_valid[i] = 1'b0;
            alarm_id[i]    = '0;
            alarm_pay[i]   = '0;
        end
        fired_id  = '0;
        accepted  = 0;
        clock_min = 0;
        hold_sent = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            for (int k = 0; k < int'(SCRIPT[r].reps); k++) begin
                req          = SCRIPT[r].req;
                req.event_id = req.event_id + ID_W'(k);
                offer_request(req, SCRIPT[r].has_answer, SCRIPT[r].answer);
            end
        end

        // random traffic, mostly well formed: live ids for remove and retime,
        // tick times that land on stored alarms or walk a running day clock
        while (accepted < RANDOM_ITEMS) begin
            calm_stretch = (accepted >= 500 && accepted < 700);
            if (accepted == 250 && !hold_sent) begin
                hold_sent    = 1'b1;
                hold_request = 1'b1;
            end
            req.hours    = HOUR_W'($urandom);
            req.minutes  = MIN_W'($urandom);
            req.payload  = PAY_W'($urandom);
            req.event_id = ID_W'($urandom);
            roll = $urandom_range(99);
            sub  = $urandom_range(9);
            if (roll < 3) begin
                req.action = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            end else if (roll < 35) begin
                req.action = ACT_TICK;
                if (sub < 5) begin
                    // tick on the time of a stored alarm
                    live = pick_live_id();
                    {req.hours, req.minutes} = live[ID_W-1:MIN_SHIFT];
                end else if (sub < 8) begin
                    // day clock moving forward one minute
                    clock_min    = (clock_min + 1) % 1440;
                    req.hours    = HOUR_W'(clock_min / 60);
                    req.minutes  = MIN_W'(clock_min % 60);
                end
            end else if (roll < 55) begin
                req.action = ACT_ADD_TIME;
                if (sub < 2) begin
                    // same time and payload as a stored alarm
                    live = pick_live_id();
                    {req.hours, req.minutes} = live[ID_W-1:MIN_SHIFT];
                    req.payload = live[PAY_W-1:0];
                end else if (sub < 9) begin
                    req.hours   = HOUR_W'($urandom_range(23));
                    req.minutes = MIN_W'($urandom_range(59));
                end
            end else if (roll < 63) begin
                req.action = ACT_ADD_ID;
                if (sub < 3)
                    req.event_id = pick_live_id();
            end else if (roll < 83) begin
                req.action = ACT_REMOVE;
                if (sub < 8)
                    req.event_id = pick_live_id();
            end else begin
                req.action = ACT_RETIME;
                if (sub < 8)
                    req.event_id = pick_live_id();
                if ($urandom_range(9) < 8) begin
                    req.hours   = HOUR_W'($urandom_range(23));
                    req.minutes = MIN_W'($urandom_range(59));
                end
            end
            offer_request(req, 1'b0, RES_OK);
            if (req.action <= ACT_TICK)
                accepted++;
        end
        calm_stretch = 1'b0;
        s_valid <= 1'b0;

        // drain, then a few more cycles to catch anything extra
        while (alarm_outcomes_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tdes_pkg.sv
hw/rtl/tdes_ram.sv
hw/rtl/time_of_day_event_scheduler_top.sv
hw/rtl/tdes_checker.sv
tb/sv/tb_time_of_day_event_scheduler_top.sv
